>>> rtl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

    // Default window store geometry
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 32;

    // Smallest usable window including the frame
    localparam int MIN_DIM = 3;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_COLS = 1'b0;
    localparam logic [0:0] REG_ROWS = 1'b1;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET = 6'd25;

    // Field widths
    localparam int MODE_W = 2;
    localparam int CODE_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 24;

    // Command kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    // Key codes with a meaning of their own
    localparam logic [CODE_W-1:0] CODE_ENTER     = 8'd13;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CODE_ESCAPE    = 8'd27;
    localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
    localparam logic [CODE_W-1:0] CODE_EXTENDED  = 8'd0;

endpackage

>>> rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps

// Framed text window with cursor, wrap and scroll.
// Commands enter on the s_axis stream: tuser holds the mode (put, read
// cell, clear), tdata the key code and the cell to read. Each command
// returns one transfer on m_axis with the cursor after the command, the
// read character (zero for other modes) and a scroll flag.
// The window size is set through the APB port: columns at 0x0, rows at
// 0x4, both counting the frame; write them only while no command is open.
// A put without scroll, backspace, enter without scroll, a read or an
// ignored code goes to S_DONE, which loads the result into the output
// register once it is free; a new command is taken only after that.
// A scroll adds a walk of the store: copy rows 2..last one row up, a
// drain step (neither with a single inner row), then zero the bottom row.
// A clear adds a walk that zeroes all inner cells. The single write
// port of the store sets this.
// After reset the store is cleared one cell per cycle, all MAX_ROWS times
// 2**clog2(MAX_COLS) cells (4096 by default); no command is taken then.
// If the receiver stalls, the result waits in the output register; one
// more command is taken and held finished until the output frees up.
module text_console_cursor_scroll #(
    parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tccs_pkg::PADDR_W-1:0]        paddr,
    input  logic [tccs_pkg::PDATA_W-1:0]        pwdata,
    output logic [tccs_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // commands
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // char_code [7:0], read_row [12:8], read_col [19:13], zero pad
    input  logic [tccs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode [1:0]
    input  logic [tccs_pkg::MODE_W-1:0]         s_axis_tuser,
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cursor_col [6:0], cursor_row [11:7], cell_char [19:12],
    // did_scroll [20], zero pad
    output logic [tccs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);

    logic [CW-1:0]               last_col;
    logic [RW-1:0]               last_row;
    logic                        we, re;
    logic [AW-1:0]               wa, ra;
    logic [tccs_pkg::CODE_W-1:0] wd, rd;
    logic [tccs_pkg::OCOL_W-1:0] cur_col;
    logic [tccs_pkg::OROW_W-1:0] cur_row;
    logic [tccs_pkg::CODE_W-1:0] cell_char;
    logic                        scroll;

    tccs_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_last_col (last_col),
        .o_last_row (last_row)
    );

    tccs_ram #(
        .WIDTH (tccs_pkg::CODE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk (i_clk),
        .i_we  (we),
        .i_wa  (wa),
        .i_wd  (wd),
        .i_re  (re),
        .i_ra  (ra),
        .o_rd  (rd)
    );

    tccs_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_code     (s_axis_tdata[7:0]),
        .i_read_row (s_axis_tdata[12:8]),
        .i_read_col (s_axis_tdata[19:13]),
        .i_last_col (last_col),
        .i_last_row (last_row),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_cur_col  (cur_col),
        .o_cur_row  (cur_row),
        .o_cell     (cell_char),
        .o_scroll   (scroll),
        .o_we       (we),
        .o_wa       (wa),
        .o_wd       (wd),
        .o_re       (re),
        .o_ra       (ra),
        .i_rd       (rd)
    );

    // Result packing
    assign m_axis_tdata = {3'd0, scroll, cell_char, cur_row, cur_col};

endmodule

>>> rtl/tccs_ram.sv
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

>>> rtl/tccs_cfg.sv
`timescale 1ns / 1ps

module tccs_cfg #(
    parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
    output logic [tccs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [$clog2(MAX_COLS)-1:0]   o_last_col,
    output logic [$clog2(MAX_ROWS)-1:0]   o_last_row
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [7:0]  r_cols;
    logic [5:0]  r_rows;
    logic [31:0] cols_sat;
    logic [31:0] rows_sat;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= tccs_pkg::COLS_RESET;
            r_rows <= tccs_pkg::ROWS_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                tccs_pkg::REG_COLS: r_cols <= pwdata[7:0];
                tccs_pkg::REG_ROWS: r_rows <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            tccs_pkg::REG_COLS: prdata = {24'd0, r_cols};
            tccs_pkg::REG_ROWS: prdata = {26'd0, r_rows};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Window size in use, saturated to the store
    always_comb begin
        cols_sat = 32'(r_cols);
        if (cols_sat < 32'(tccs_pkg::MIN_DIM)) begin
            cols_sat = 32'(tccs_pkg::MIN_DIM);
        end else if (cols_sat > 32'(MAX_COLS)) begin
            cols_sat = 32'(MAX_COLS);
        end
        rows_sat = 32'(r_rows);
        if (rows_sat < 32'(tccs_pkg::MIN_DIM)) begin
            rows_sat = 32'(tccs_pkg::MIN_DIM);
        end else if (rows_sat > 32'(MAX_ROWS)) begin
            rows_sat = 32'(MAX_ROWS);
        end
    end

    // Last inner column and row
    assign o_last_col = CW'(cols_sat - 32'd2);
    assign o_last_row = RW'(rows_sat - 32'd2);

endmodule

>>> rtl/tccs_seq.sv
`timescale 1ns / 1ps

module tccs_seq #(
    parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    // command side
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [tccs_pkg::MODE_W-1:0]                    i_mode,
    input  logic [tccs_pkg::CODE_W-1:0]                    i_code,
    input  logic [tccs_pkg::RROW_W-1:0]                    i_read_row,
    input  logic [tccs_pkg::RCOL_W-1:0]                    i_read_col,
    // window limits
    input  logic [$clog2(MAX_COLS)-1:0]                    i_last_col,
    input  logic [$clog2(MAX_ROWS)-1:0]                    i_last_row,
    // result side
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic [tccs_pkg::OCOL_W-1:0]                    o_cur_col,
    output logic [tccs_pkg::OROW_W-1:0]                    o_cur_row,
    output logic [tccs_pkg::CODE_W-1:0]                    o_cell,
    output logic                                           o_scroll,
    // character store
    output logic                                           o_we,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]   o_wa,
    output logic [tccs_pkg::CODE_W-1:0]                    o_wd,
    output logic                                           o_re,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0]   o_ra,
    input  logic [tccs_pkg::CODE_W-1:0]                    i_rd
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [RW-1:0] ONE_R = RW'(1);
    localparam logic [RW-1:0] TWO_R = RW'(2);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_COPY,
        S_DRAIN,
        S_ZERO,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_init_addr, n_init_addr;
    logic [CW-1:0]               r_cur_c, n_cur_c;
    logic [RW-1:0]               r_cur_r, n_cur_r;
    logic [CW-1:0]               r_col, n_col;
    logic [RW-1:0]               r_row, n_row;
    logic                        r_pend, n_pend;
    logic [AW-1:0]               r_pend_addr, n_pend_addr;
    logic                        r_is_read, n_is_read;
    logic                        r_rd_zero, n_rd_zero;
    logic                        r_scroll, n_scroll;
    logic                        r_out_valid, n_out_valid;
    logic [tccs_pkg::OCOL_W-1:0] r_out_c, n_out_c;
    logic [tccs_pkg::OROW_W-1:0] r_out_r, n_out_r;
    logic [tccs_pkg::CODE_W-1:0] r_out_cell, n_out_cell;
    logic                        r_out_scroll, n_out_scroll;

    logic [CW-1:0]               ec;
    logic [RW-1:0]               er;
    logic                        wrap;
    logic                        we, re;
    logic [AW-1:0]               wa, ra;
    logic [tccs_pkg::CODE_W-1:0] wd;

    // Cursor held inside the window after a size change
    assign ec = (r_cur_c > i_last_col) ? i_last_col : r_cur_c;
    assign er = (r_cur_r > i_last_row) ? i_last_row : r_cur_r;

    assign o_ready = (r_state == S_IDLE);

    // Command sequencer and store access
    always_comb begin
        n_state      = r_state;
        n_init_addr  = r_init_addr;
        n_cur_c      = r_cur_c;
        n_cur_r      = r_cur_r;
        n_col        = r_col;
        n_row        = r_row;
        n_pend       = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_is_read    = r_is_read;
        n_rd_zero    = r_rd_zero;
        n_scroll     = r_scroll;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_c      = r_out_c;
        n_out_r      = r_out_r;
        n_out_cell   = r_out_cell;
        n_out_scroll = r_out_scroll;
        wrap         = 1'b0;
        we           = 1'b0;
        wa           = r_pend_addr;
        wd           = '0;
        re           = 1'b0;
        ra           = {r_row, r_col};

        case (r_state)
            S_INIT: begin
                // clear the whole store after reset
                we          = 1'b1;
                wa          = r_init_addr;
                n_init_addr = r_init_addr + AW'(1);
                if (r_init_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cur_c = ec;
                n_cur_r = er;
                if (i_valid) begin
                    n_is_read = 1'b0;
                    n_rd_zero = 1'b0;
                    n_scroll  = 1'b0;
                    n_state   = S_DONE;
                    case (i_mode)
                        tccs_pkg::MODE_PUT: begin
                            if (i_code == tccs_pkg::CODE_ENTER) begin
                                wrap = 1'b1;
                            end else if (i_code == tccs_pkg::CODE_BACKSPACE) begin
                                // step back across rows, never before home
                                if (ec > ONE_C) begin
                                    n_cur_c = ec - ONE_C;
                                end else if (er > ONE_R) begin
                                    n_cur_r = er - ONE_R;
                                    n_cur_c = i_last_col;
                                end
                                we = 1'b1;
                                wa = {n_cur_r, n_cur_c};
                            end else if (i_code == tccs_pkg::CODE_ESCAPE ||
                                         i_code == tccs_pkg::CODE_TAB ||
                                         i_code == tccs_pkg::CODE_EXTENDED) begin
                                n_state = S_DONE;
                            end else begin
                                we = 1'b1;
                                wa = {er, ec};
                                wd = i_code;
                                if (ec >= i_last_col) begin
                                    wrap = 1'b1;
                                end else begin
                                    n_cur_c = ec + ONE_C;
                                end
                            end
                        end
                        tccs_pkg::MODE_READ: begin
                            re        = 1'b1;
                            ra        = {RW'(i_read_row), CW'(i_read_col)};
                            n_is_read = 1'b1;
                            n_rd_zero = (32'(i_read_row) >= 32'(MAX_ROWS)) ||
                                        (32'(i_read_col) >= 32'(MAX_COLS));
                        end
                        tccs_pkg::MODE_CLEAR: begin
                            n_cur_c = ONE_C;
                            n_cur_r = ONE_R;
                            n_col   = ONE_C;
                            n_row   = ONE_R;
                            n_state = S_ZERO;
                        end
                        default: ;
                    endcase

                    // new line, scrolling at the bottom row
                    if (wrap) begin
                        n_cur_c = ONE_C;
                        if (er >= i_last_row) begin
                            n_cur_r  = i_last_row;
                            n_scroll = 1'b1;
                            n_col    = ONE_C;
                            if (i_last_row >= TWO_R) begin
                                n_row   = TWO_R;
                                n_state = S_COPY;
                            end else begin
                                n_row   = i_last_row;
                                n_state = S_ZERO;
                            end
                        end else begin
                            n_cur_r = er + ONE_R;
                        end
                    end
                end
            end
            S_COPY: begin
                // read a cell, write it one row up on the next cycle
                re          = 1'b1;
                ra          = {r_row, r_col};
                n_pend      = 1'b1;
                n_pend_addr = {r_row - ONE_R, r_col};
                we          = r_pend;
                wa          = r_pend_addr;
                wd          = i_rd;
                if (r_col == i_last_col) begin
                    n_col = ONE_C;
                    if (r_row == i_last_row) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_row = r_row + ONE_R;
                    end
                end else begin
                    n_col = r_col + ONE_C;
                end
            end
            S_DRAIN: begin
                we      = r_pend;
                wa      = r_pend_addr;
                wd      = i_rd;
                n_row   = i_last_row;
                n_col   = ONE_C;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                // zero rows r_row..last, inner columns only
                we = 1'b1;
                wa = {r_row, r_col};
                if (r_col == i_last_col) begin
                    n_col = ONE_C;
                    if (r_row == i_last_row) begin
                        n_state = S_DONE;
                    end else begin
                        n_row = r_row + ONE_R;
                    end
                end else begin
                    n_col = r_col + ONE_C;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_c      = tccs_pkg::OCOL_W'(r_cur_c);
                    n_out_r      = tccs_pkg::OROW_W'(r_cur_r);
                    n_out_cell   = (r_is_read && !r_rd_zero) ? i_rd : '0;
                    n_out_scroll = r_scroll;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_cur_c     <= ONE_C;
            r_cur_r     <= ONE_R;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_cur_c     <= n_cur_c;
            r_cur_r     <= n_cur_r;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_col        <= n_col;
        r_row        <= n_row;
        r_pend_addr  <= n_pend_addr;
        r_is_read    <= n_is_read;
        r_rd_zero    <= n_rd_zero;
        r_scroll     <= n_scroll;
        r_out_c      <= n_out_c;
        r_out_r      <= n_out_r;
        r_out_cell   <= n_out_cell;
        r_out_scroll <= n_out_scroll;
    end

    assign o_valid   = r_out_valid;
    assign o_cur_col = r_out_c;
    assign o_cur_row = r_out_r;
    assign o_cell    = r_out_cell;
    assign o_scroll  = r_out_scroll;
    assign o_we      = we;
    assign o_wa      = wa;
    assign o_wd      = wd;
    assign o_re      = re;
    assign o_ra      = ra;

`ifndef NO_ASSERTIONS
    // a scroll copy never writes the cell it reads in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && re) |-> (wa != ra))
        else $error("store read and write hit the same cell");

    // a pending copy write only follows a copy read
    a_pend_from_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == S_COPY))
        else $error("copy write without a copy read");

    // finishing a command always presents a result
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_ready)) |=> r_out_valid)
        else $error("result not loaded at command end");

    // a scroll leaves the cursor at the first inner column
    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scroll) |-> (r_out_c == tccs_pkg::OCOL_W'(1)))
        else $error("scroll with cursor off the first column");
`endif

endmodule
